// ===== rtl/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// pit_pkg
// shared widths, types, latencies and division step helpers for the
// point-in-triangle test pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

  localparam int COORD_WIDTH         = 32;
  localparam int DIFF_W              = COORD_WIDTH + 1;
  localparam int PROD_W              = 2 * COORD_WIDTH;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = PROD_W / DIV_STEPS_PER_STAGE;
  localparam int DIV_LAT             = DIV_STAGES + 1;
  localparam int FRONT_LAT           = 2;
  localparam int DECIDE_LAT          = 2;
  localparam int PY_LAT              = FRONT_LAT + DIV_LAT;
  localparam int LATENCY             = 1 + FRONT_LAT + DIV_LAT + DECIDE_LAT;

  localparam int NUM_EDGES = 3;
  localparam int EDGE_AB   = 0;
  localparam int EDGE_BC   = 1;
  localparam int EDGE_AC   = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-1:0]        mag_t;
  typedef logic [PROD_W-1:0]             prod_t;

  typedef struct packed {
    logic   valid;
    logic   cnt;
    coord_t y0;
    prod_t  num0;
    prod_t  num1;
    logic   neg0;
    logic   neg1;
    mag_t   den;
  } front_t;

  typedef struct packed {
    mag_t  rem;
    prod_t num;
    mag_t  quot;
    mag_t  den;
    logic  neg;
  } div_state_t;

  function automatic mag_t abs_val(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? n[COORD_WIDTH-1:0] : v[COORD_WIDTH-1:0];
  endfunction

  // one restoring step: bring down a numerator bit, subtract if it fits
  function automatic div_state_t div_step(input div_state_t s);
    logic [COORD_WIDTH:0]   trial;
    logic [COORD_WIDTH+1:0] diff;
    div_state_t             r;
    r     = s;
    trial = {s.rem, s.num[PROD_W-1]};
    diff  = {1'b0, trial} - {2'b00, s.den};
    r.num = {s.num[PROD_W-2:0], 1'b0};
    if (!diff[COORD_WIDTH+1]) begin
      r.rem  = diff[COORD_WIDTH-1:0];
      r.quot = {s.quot[COORD_WIDTH-2:0], 1'b1};
    end else begin
      r.rem  = trial[COORD_WIDTH-1:0];
      r.quot = {s.quot[COORD_WIDTH-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_state_t div_stage(input div_state_t s);
    div_state_t r;
    r = s;
    for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
      r = div_step(r);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pit_edge_front.sv =====
// ----------------------------------------------------------------------------
// pit_edge_front
// per-edge front end: differences, magnitudes and span test, then the two
// magnitude products that feed the dividers
// ----------------------------------------------------------------------------
`default_nettype none

module pit_edge_front
  import pit_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire coord_t x0,
  input  wire coord_t y0,
  input  wire coord_t x1,
  input  wire coord_t y1,
  input  wire coord_t xt,
  output front_t      res
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic                     cnt;

  logic   a_valid;
  logic   a_cnt;
  coord_t a_y0;
  mag_t   a_dxm;
  mag_t   a_dym;
  mag_t   a_x0m;
  mag_t   a_xtm;
  logic   a_sdx;
  logic   a_sdy;
  logic   a_sx0;
  logic   a_sxt;

  always_comb begin
    dx  = DIFF_W'(x1) - DIFF_W'(x0);
    dy  = DIFF_W'(y1) - DIFF_W'(y0);
    cnt = (xt > x0 && xt < x1) || (xt > x1 && xt < x0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_cnt <= cnt;
    a_y0  <= y0;
    a_dxm <= abs_val(dx);
    a_dym <= abs_val(dy);
    a_x0m <= abs_val(DIFF_W'(x0));
    a_xtm <= abs_val(DIFF_W'(xt));
    a_sdx <= dx[DIFF_W-1];
    a_sdy <= dy[DIFF_W-1];
    a_sx0 <= x0[COORD_WIDTH-1];
    a_sxt <= xt[COORD_WIDTH-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= a_valid;
    end
    res.cnt  <= a_cnt;
    res.y0   <= a_y0;
    res.num0 <= PROD_W'(a_dym) * PROD_W'(a_x0m);
    res.num1 <= PROD_W'(a_xtm) * PROD_W'(a_dym);
    res.neg0 <= a_sdy ^ a_sx0 ^ a_sdx;
    res.neg1 <= a_sxt ^ a_sdy ^ a_sdx;
    res.den  <= a_dxm;
  end

endmodule

`default_nettype wire

// ===== rtl/pit_divider.sv =====
// ----------------------------------------------------------------------------
// pit_divider
// pipelined restoring divider on magnitudes, truncating toward zero; keeps
// the low coordinate bits of the signed quotient
// ----------------------------------------------------------------------------
`default_nettype none

module pit_divider
  import pit_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire prod_t num,
  input  wire mag_t  den,
  input  wire logic  neg,
  output logic       out_valid,
  output coord_t     quot
);

  localparam int LAST = DIV_STAGES - 1;

  div_state_t              seed;
  div_state_t              pipe [DIV_STAGES];
  logic [DIV_STAGES-1:0]   vld;

  always_comb begin
    seed.rem  = '0;
    seed.num  = num;
    seed.quot = '0;
    seed.den  = den;
    seed.neg  = neg;
  end

  always_ff @(posedge clk) begin
    pipe[0] <= div_stage(seed);
    for (int s = 1; s < DIV_STAGES; s++) begin
      pipe[s] <= div_stage(pipe[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[DIV_STAGES-2:0], in_valid};
      out_valid <= vld[LAST];
    end
  end

  // sign fix-up; high quotient bits have already been shifted out
  always_ff @(posedge clk) begin
    quot <= pipe[LAST].neg ? coord_t'(-pipe[LAST].quot) : coord_t'(pipe[LAST].quot);
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] |-> (pipe[LAST].rem < pipe[LAST].den || pipe[LAST].den == '0))
    else $error("divider remainder not below divisor");

  a_valid_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, DIV_LAT))
    else $error("divider valid out of step with its input");

endmodule

`default_nettype wire

// ===== rtl/pit_decide.sv =====
// ----------------------------------------------------------------------------
// pit_decide
// edge y values from the quotients, pick the two counted edges and test
// the point y against them
// ----------------------------------------------------------------------------
`default_nettype none

module pit_decide
  import pit_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [NUM_EDGES-1:0]  cnt,
  input  wire coord_t [NUM_EDGES-1:0] y0,
  input  wire coord_t [NUM_EDGES-1:0] q0,
  input  wire coord_t [NUM_EDGES-1:0] q1,
  input  wire coord_t                py,
  output logic                       done,
  output logic                       inside_res
);

  logic                   s1_valid;
  logic [NUM_EDGES-1:0]   s1_cnt;
  coord_t [NUM_EDGES-1:0] s1_y;
  coord_t                 s1_py;

  logic   pair_ok;
  coord_t ya;
  coord_t yb;
  logic   in_tri;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_cnt <= cnt;
    s1_py  <= py;
    for (int e = 0; e < NUM_EDGES; e++) begin
      s1_y[e] <= y0[e] + q1[e] - q0[e];
    end
  end

  always_comb begin
    pair_ok = ($countones(s1_cnt) == 2);
    ya      = s1_cnt[EDGE_AB] ? s1_y[EDGE_AB] : s1_y[EDGE_BC];
    yb      = s1_cnt[EDGE_AC] ? s1_y[EDGE_AC] : s1_y[EDGE_BC];
    in_tri  = pair_ok && ((s1_py > ya && s1_py < yb) || (s1_py > yb && s1_py < ya));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      done       <= s1_valid;
      inside_res <= s1_valid & in_tri;
    end
  end

  a_inside_two_edges: assert property (@(posedge clk) disable iff (rst)
    inside_res |-> $past($countones(cnt) == 2, 2))
    else $error("inside reported without exactly two counted edges");

endmodule

`default_nettype wire

// ===== rtl/point_in_triangle_test.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_test
// strict point-in-triangle test, fully pipelined
// ----------------------------------------------------------------------------
// An item (three vertices and a test point) is taken at a rising edge with
// start high and busy low. busy is always low: one item can enter every
// cycle and the pipeline never stalls.
// Each item gives one result on inside_res, marked by done for exactly one
// cycle. Results leave in the order items entered.
// Pipeline stages: one input register, two front-end stages per edge
// (differences, then 32x32 magnitude products), the divider (64 restoring
// steps at two per stage plus a sign fix-up) and two output stages. The
// divider depth sets the latency; throughput is one item a cycle.
// Six dividers run side by side, two per edge.
// Reset clears all valid bits; items in flight are dropped and no result
// appears until a new item has passed through. The receiver has no way to
// hold results off, so none is ever buffered.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_triangle_test
  import pit_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire coord_t a_x,
  input  wire coord_t a_y,
  input  wire coord_t b_x,
  input  wire coord_t b_y,
  input  wire coord_t c_x,
  input  wire coord_t c_y,
  input  wire coord_t point_x,
  input  wire coord_t point_y,
  output logic        done,
  output logic        inside_res
);

  logic   in_valid;
  coord_t ax;
  coord_t ay;
  coord_t bx;
  coord_t by;
  coord_t cx;
  coord_t cy;
  coord_t px;
  coord_t py;

  coord_t [NUM_EDGES-1:0] ex0;
  coord_t [NUM_EDGES-1:0] ey0;
  coord_t [NUM_EDGES-1:0] ex1;
  coord_t [NUM_EDGES-1:0] ey1;

  front_t                 fr [NUM_EDGES];
  logic [NUM_EDGES-1:0]   v0;
  logic [NUM_EDGES-1:0]   v1;
  coord_t [NUM_EDGES-1:0] q0;
  coord_t [NUM_EDGES-1:0] q1;

  logic [NUM_EDGES-1:0]   cnt_dly [DIV_LAT];
  coord_t [NUM_EDGES-1:0] y0_dly  [DIV_LAT];
  coord_t                 py_dly  [PY_LAT];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
    ax <= a_x;
    ay <= a_y;
    bx <= b_x;
    by <= b_y;
    cx <= c_x;
    cy <= c_y;
    px <= point_x;
    py <= point_y;
  end

  always_comb begin
    ex0[EDGE_AB] = ax; ey0[EDGE_AB] = ay; ex1[EDGE_AB] = bx; ey1[EDGE_AB] = by;
    ex0[EDGE_BC] = bx; ey0[EDGE_BC] = by; ex1[EDGE_BC] = cx; ey1[EDGE_BC] = cy;
    ex0[EDGE_AC] = ax; ey0[EDGE_AC] = ay; ex1[EDGE_AC] = cx; ey1[EDGE_AC] = cy;
  end

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
    pit_edge_front u_front (
      .clk      (clk),
      .rst      (rst),
      .in_valid (in_valid),
      .x0       (ex0[e]),
      .y0       (ey0[e]),
      .x1       (ex1[e]),
      .y1       (ey1[e]),
      .xt       (px),
      .res      (fr[e])
    );

    // offset term: dy * x0 / dx
    pit_divider u_div0 (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (fr[e].valid),
      .num       (fr[e].num0),
      .den       (fr[e].den),
      .neg       (fr[e].neg0),
      .out_valid (v0[e]),
      .quot      (q0[e])
    );

    // slope term: xt * dy / dx
    pit_divider u_div1 (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (fr[e].valid),
      .num       (fr[e].num1),
      .den       (fr[e].den),
      .neg       (fr[e].neg1),
      .out_valid (v1[e]),
      .quot      (q1[e])
    );
  end

  // side data rides alongside the dividers
  always_ff @(posedge clk) begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      cnt_dly[0][e] <= fr[e].cnt;
      y0_dly[0][e]  <= fr[e].y0;
    end
    for (int s = 1; s < DIV_LAT; s++) begin
      cnt_dly[s] <= cnt_dly[s-1];
      y0_dly[s]  <= y0_dly[s-1];
    end
    py_dly[0] <= py;
    for (int s = 1; s < PY_LAT; s++) begin
      py_dly[s] <= py_dly[s-1];
    end
  end

  pit_decide u_decide (
    .clk        (clk),
    .rst        (rst),
    .in_valid   ((&v0) & (&v1)),
    .cnt        (cnt_dly[DIV_LAT-1]),
    .y0         (y0_dly[DIV_LAT-1]),
    .q0         (q0),
    .q1         (q1),
    .py         (py_dly[PY_LAT-1]),
    .done       (done),
    .inside_res (inside_res)
  );

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without an item taken at the pipeline latency");

endmodule

`default_nettype wire
